### src/png_uf_pkg.sv
`default_nettype none

package png_uf_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int LINE_DEPTH = MAX_WIDTH * 4;
  localparam int LINE_AW    = $clog2(LINE_DEPTH);

  localparam int WIDTH_W    = 13;
  localparam int HEIGHT_W   = 16;
  localparam int BPP_W      = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int ROWB_W     = LINE_AW + 1;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam logic [BPP_W-1:0] BPP_RGBA     = 3'd4;
  localparam logic [7:0]       ALPHA_OPAQUE = 8'hFF;
  localparam logic [7:0]       FILTER_MAX   = 8'd4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH     = 2'd0,
    REG_IMAGE_HEIGHT    = 2'd1,
    REG_BYTES_PER_PIXEL = 2'd2
  } cfg_reg_e;

  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4
  } filter_e;

  // One queued operation: a sample to rebuild or a filter error to report.
  typedef struct packed {
    logic               is_err;
    logic [7:0]         raw;
    logic [LINE_AW-1:0] pos;
    logic [1:0]         k;
    filter_e            filt;
    logic               row_first;
    logic               first_row;
    logic               last_in_row;
    logic               last_row;
    logic               bpp4;
    logic               emit;
  } op_t;

endpackage

`default_nettype wire

### src/png_uf_if.sv
`default_nettype none

interface png_uf_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] raw_byte;

  modport source (output valid, output raw_byte, input ready);
  modport sink   (input valid, input raw_byte, output ready);
endinterface

interface png_uf_pix_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_argb;
  logic        end_of_row;
  logic        end_of_image;
  logic        filter_error;

  modport source (output valid, output pixel_argb, output end_of_row,
                  output end_of_image, output filter_error, input ready);
  modport sink   (input valid, input pixel_argb, input end_of_row,
                  input end_of_image, input filter_error, output ready);
endinterface

`default_nettype wire

### src/png_uf_front.sv
`default_nettype none

module png_uf_front
  import png_uf_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  in_valid_i,
  input  wire logic [7:0]            in_byte_i,
  output logic                       in_ready_o,
  input  wire logic                  q_full_i,
  output logic                       q_push_o,
  output op_t                        q_op_o
);

  logic [WIDTH_W-1:0]  width_q;
  logic [HEIGHT_W-1:0] height_q;
  logic [BPP_W-1:0]    bpp_q;

  logic                expecting_q, expecting_d;
  logic                skipping_q, skipping_d;
  logic                first_q, first_d;
  filter_e             filt_q, filt_d;
  logic [LINE_AW-1:0]  pos_q, pos_d;
  logic [1:0]          mod3_q, mod3_d;
  logic [HEIGHT_W-1:0] row_q, row_d;

  logic                accept;
  logic                bpp4;
  logic [WIDTH_W-1:0]  w_eff;
  logic [HEIGHT_W-1:0] h_eff;
  logic [ROWB_W-1:0]   row_len;
  logic                last_in_row, last_row;
  logic [1:0]          k;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_W'(1);
      height_q <= HEIGHT_W'(1);
      bpp_q    <= BPP_RGBA;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_IMAGE_WIDTH:     width_q  <= cfg_data_i[WIDTH_W-1:0];
        REG_IMAGE_HEIGHT:    height_q <= cfg_data_i[HEIGHT_W-1:0];
        REG_BYTES_PER_PIXEL: bpp_q    <= cfg_data_i[BPP_W-1:0];
        default: ;
      endcase
    end
  end

  assign bpp4  = (bpp_q == BPP_RGBA);
  assign w_eff = (width_q == '0) ? WIDTH_W'(1) :
                 (width_q > WIDTH_W'(MAX_WIDTH)) ? WIDTH_W'(MAX_WIDTH) : width_q;
  assign h_eff = (height_q == '0) ? HEIGHT_W'(1) : height_q;
  assign row_len = bpp4 ? {w_eff, 2'b00} :
                   (ROWB_W'(w_eff) + ROWB_W'({w_eff, 1'b0}));

  assign last_in_row = ({1'b0, pos_q} + ROWB_W'(1)) >= row_len;
  assign last_row    = ({1'b0, row_q} + 17'd1) >= {1'b0, h_eff};
  assign k           = bpp4 ? pos_q[1:0] : mod3_q;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    expecting_d = expecting_q;
    skipping_d  = skipping_q;
    first_d     = first_q;
    filt_d      = filt_q;
    pos_d       = pos_q;
    mod3_d      = mod3_q;
    row_d       = row_q;
    q_push_o    = 1'b0;

    q_op_o.is_err      = 1'b0;
    q_op_o.raw         = in_byte_i;
    q_op_o.pos         = pos_q;
    q_op_o.k           = k;
    q_op_o.filt        = filt_q;
    q_op_o.row_first   = first_q;
    q_op_o.first_row   = (row_q == '0);
    q_op_o.last_in_row = last_in_row;
    q_op_o.last_row    = last_row;
    q_op_o.bpp4        = bpp4;
    q_op_o.emit        = bpp4 ? (k == 2'd3) : (k == 2'd2);

    if (accept) begin
      if (expecting_q) begin
        expecting_d = 1'b0;
        pos_d       = '0;
        mod3_d      = '0;
        first_d     = 1'b1;
        if (!skipping_q) begin
          if (in_byte_i > FILTER_MAX) begin
            skipping_d    = 1'b1;
            q_op_o.is_err = 1'b1;
            q_push_o      = 1'b1;
          end else begin
            filt_d = filter_e'(in_byte_i[2:0]);
          end
        end
      end else begin
        q_push_o = !skipping_q;
        first_d  = 1'b0;
        if (last_in_row) begin
          expecting_d = 1'b1;
          if (last_row) begin
            row_d      = '0;
            skipping_d = 1'b0;
          end else begin
            row_d = row_q + HEIGHT_W'(1);
          end
        end else begin
          pos_d  = pos_q + LINE_AW'(1);
          mod3_d = (mod3_q == 2'd2) ? 2'd0 : mod3_q + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expecting_q <= 1'b1;
      skipping_q  <= 1'b0;
      first_q     <= 1'b0;
      filt_q      <= FILT_NONE;
      pos_q       <= '0;
      mod3_q      <= '0;
      row_q       <= '0;
    end else begin
      expecting_q <= expecting_d;
      skipping_q  <= skipping_d;
      first_q     <= first_d;
      filt_q      <= filt_d;
      pos_q       <= pos_d;
      mod3_q      <= mod3_d;
      row_q       <= row_d;
    end
  end

endmodule

`default_nettype wire

### src/png_uf_fifo.sv
`default_nettype none

module png_uf_fifo
  import png_uf_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  op_t       data_i,
  input  wire logic pop_i,
  output op_t       data_o,
  output logic      empty_o,
  output logic      full_o
);

  op_t                mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_AW:0]   count_q;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == (FIFO_AW+1)'(FIFO_DEPTH));
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + (FIFO_AW+1)'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - (FIFO_AW+1)'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o && !pop_i |-> !push_i) else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i) else $error("queue pop while empty");

endmodule

`default_nettype wire

### src/png_uf_back.sv
`default_nettype none

module png_uf_back
  import png_uf_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   q_empty_i,
  input  op_t         q_op_i,
  output logic        q_pop_o,
  output logic        out_valid_o,
  input  wire logic   out_ready_i,
  output logic [31:0] pixel_argb_o,
  output logic        end_of_row_o,
  output logic        end_of_image_o,
  output logic        filter_error_o
);

  logic [7:0]  line_mem [LINE_DEPTH];
  logic [7:0]  up_rd_q;

  logic        s1_valid_q;
  op_t         s1_op_q;
  logic [31:0] left_q, left_d;
  logic [31:0] upleft_q, upleft_d;
  logic [23:0] asm_q, asm_d;

  logic        out_valid_q;
  logic [31:0] out_pixel_q;
  logic        out_eor_q, out_eoi_q, out_err_q;

  logic        out_free, s1_needs_out, s1_adv, s1_fire, mem_we;
  logic [31:0] left_base, upleft_base;
  logic [7:0]  a, b, c, pred, recon;
  logic [8:0]  avg_sum;
  logic [9:0]  pa, pb, pc;

  function automatic logic [9:0] abs10(input logic signed [9:0] v);
    abs10 = v[9] ? 10'(-v) : 10'(v);
  endfunction

  assign out_free     = !out_valid_q || out_ready_i;
  assign s1_needs_out = s1_op_q.is_err || s1_op_q.emit;
  assign s1_adv       = !s1_valid_q || !s1_needs_out || out_free;
  assign s1_fire      = s1_valid_q && s1_adv;
  assign q_pop_o      = !q_empty_i && s1_adv;
  assign mem_we       = s1_fire && !s1_op_q.is_err;

  // Line buffer: registered read at pop, write when the sample retires.
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      up_rd_q <= line_mem[q_op_i.pos];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      line_mem[s1_op_q.pos] <= recon;
    end
  end

  // Neighbours restart at zero on the first sample of each row.
  assign left_base   = s1_op_q.row_first ? '0 : left_q;
  assign upleft_base = s1_op_q.row_first ? '0 : upleft_q;
  assign a = left_base[s1_op_q.k*8 +: 8];
  assign c = upleft_base[s1_op_q.k*8 +: 8];
  assign b = s1_op_q.first_row ? 8'd0 : up_rd_q;

  assign avg_sum = {1'b0, a} + {1'b0, b};
  assign pa = abs10($signed({2'b00, b}) - $signed({2'b00, c}));
  assign pb = abs10($signed({2'b00, a}) - $signed({2'b00, c}));
  assign pc = abs10($signed({2'b00, a}) + $signed({2'b00, b}) - $signed({1'b0, c, 1'b0}));

  always_comb begin
    unique case (s1_op_q.filt)
      FILT_SUB:   pred = a;
      FILT_UP:    pred = b;
      FILT_AVG:   pred = avg_sum[8:1];
      FILT_PAETH: begin
        if (pa <= pb && pa <= pc) begin
          pred = a;
        end else if (pb <= pc) begin
          pred = b;
        end else begin
          pred = c;
        end
      end
      default:    pred = 8'd0;
    endcase
  end

  assign recon = s1_op_q.raw + pred;

  always_comb begin
    left_d   = left_base;
    upleft_d = upleft_base;
    asm_d    = asm_q;
    left_d[s1_op_q.k*8 +: 8]   = recon;
    upleft_d[s1_op_q.k*8 +: 8] = b;
    case (s1_op_q.k)
      2'd0:    asm_d[23:16] = recon;
      2'd1:    asm_d[15:8]  = recon;
      2'd2:    asm_d[7:0]   = recon;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      s1_op_q <= q_op_i;
    end
    if (s1_fire && s1_needs_out) begin
      if (s1_op_q.is_err) begin
        out_pixel_q <= '0;
        out_eor_q   <= 1'b0;
        out_eoi_q   <= 1'b0;
        out_err_q   <= 1'b1;
      end else begin
        out_pixel_q <= {s1_op_q.bpp4 ? recon : ALPHA_OPAQUE, asm_d};
        out_eor_q   <= s1_op_q.last_in_row;
        out_eoi_q   <= s1_op_q.last_in_row && s1_op_q.last_row;
        out_err_q   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      left_q      <= '0;
      upleft_q    <= '0;
      asm_q       <= '0;
    end else begin
      if (s1_adv) begin
        s1_valid_q <= q_pop_o;
      end
      out_valid_q <= (out_valid_q && !out_ready_i) || (s1_fire && s1_needs_out);
      if (mem_we) begin
        left_q   <= left_d;
        upleft_q <= upleft_d;
        asm_q    <= asm_d;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pixel_argb_o   = out_pixel_q;
  assign end_of_row_o   = out_eor_q;
  assign end_of_image_o = out_eoi_q;
  assign filter_error_o = out_err_q;

  a_eoi_implies_eor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_eoi_q |-> out_eor_q) else $error("image end without row end");

  a_err_result_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_err_q |-> out_pixel_q == '0 && !out_eor_q && !out_eoi_q)
    else $error("error transaction carries pixel data");

endmodule

`default_nettype wire

### src/png_scanline_unfilter.sv
// Channel   Dir  Transaction payload                              Handshake
// in_if     in   raw_byte[7:0]                                    valid/ready
// out_if    out  pixel_argb[31:0], end_of_row, end_of_image,       valid/ready
//                filter_error
//
// One byte per cycle sustained while out_if.ready stays high. A pixel's last byte
// is queued, loaded into the stage with the line buffer read, then output registered.
// The line buffer has a single read and a single write port, each used once per sample byte.
// Reset clears control, configuration and neighbour state; the line buffer is not cleared.
// An unaccepted output stalls the back end; the four-entry queue then fills
// and in_if.ready drops.
`default_nettype none

module png_scanline_unfilter
  import png_uf_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  png_uf_byte_if.sink                in_if,
  png_uf_pix_if.source               out_if
);

  logic q_push, q_pop, q_empty, q_full;
  op_t  q_in_op, q_out_op;

  png_uf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_if.valid),
    .in_byte_i  (in_if.raw_byte),
    .in_ready_o (in_if.ready),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_op_o     (q_in_op)
  );

  png_uf_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_in_op),
    .pop_i   (q_pop),
    .data_o  (q_out_op),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  png_uf_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_empty_i      (q_empty),
    .q_op_i         (q_out_op),
    .q_pop_o        (q_pop),
    .out_valid_o    (out_if.valid),
    .out_ready_i    (out_if.ready),
    .pixel_argb_o   (out_if.pixel_argb),
    .end_of_row_o   (out_if.end_of_row),
    .end_of_image_o (out_if.end_of_image),
    .filter_error_o (out_if.filter_error)
  );

endmodule

`default_nettype wire
